// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the translator RTL.
// Each macro expands to a labeled concurrent assertion, or to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked assertion, disabled while reset is held.
`define SAT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("segment translator assertion failed");
// Implication form of the same check.
`define SAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `SAT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))
`else
`define SAT_ASSERT(lbl, clk, rst_n, prop)
`define SAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/sat_pkg.sv =====
// Package for the segment address translator: sizes, codes, item and port types.
// No dependencies; every RTL file of the block imports it.
`default_nettype none

package sat_pkg;

  // Sizes of the register bank.
  localparam int NumSegments = 8;
  localparam int NumRegs     = 20;
  localparam int RegIdxW     = $clog2(NumRegs);

  // Status and flag bit positions and compare masks.
  localparam int          PmBit      = 0;
  localparam int          SegEnBit   = 15;
  localparam int          SegProtBit = 0;
  localparam logic [15:0] FeMask     = 16'd2;
  localparam logic [15:0] RrwMask    = 16'd4;
  localparam logic [15:0] FrwMask    = 16'd24;

  // Item kinds.
  localparam logic [1:0] KindXlate = 2'd0;
  localparam logic [1:0] KindRead  = 2'd1;
  localparam logic [1:0] KindWrite = 2'd2;

  // Fault codes.
  localparam logic [2:0] FaultNone  = 3'd0;
  localparam logic [2:0] FaultProt  = 3'd1;
  localparam logic [2:0] FaultExec  = 3'd2;
  localparam logic [2:0] FaultRw    = 3'd3;
  localparam logic [2:0] FaultNoSeg = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] virt_addr;
    logic [31:0] cpu_status;
  } sat_in_t;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic [2:0]  fault_code;
    logic [31:0] read_data;
  } sat_out_t;

  // Register bank write request.
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [31:0]        data;
  } sat_wr_t;

  typedef logic [NumRegs-1:0][31:0] sat_bank_t;

endpackage

`default_nettype wire

// ===== rtl/core/segment_address_translator_core.sv =====
// An accepted item is held in the input register; its result is written into the result
// register when that register is free or being taken, and is offered on the output from there.
// Throughput: one item per cycle while out_stall_i is low; the input register feeds
// the result register through the segment match and check logic, and a register write
// lands in the same edge that moves its item on, so the next item sees it.
// Reset clears all bank registers to zero (segments disabled) and empties both stages.
// Depends on sat_pkg, sat_regfile, sat_xlate and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module segment_address_translator_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sat_pkg::sat_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sat_pkg::sat_out_t      out_data_o
);
  import sat_pkg::*;

  logic      in_valid_q;
  sat_in_t   in_q;
  logic      out_valid_q;
  sat_out_t  out_q;
  logic      adv;
  sat_out_t  res;
  sat_wr_t   xl_wr;
  sat_wr_t   wr;
  sat_bank_t bank;

  // The held item moves on when the result register is free or being taken.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  sat_xlate u_xlate (
    .item_i (in_q),
    .bank_i (bank),
    .res_o  (res),
    .wr_o   (xl_wr)
  );

  // A write commits only as its item leaves the input register.
  always_comb begin
    wr    = xl_wr;
    wr.en = xl_wr.en && adv;
  end

  sat_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .bank_o (bank)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SAT_ASSERT_IMP(a_wr_only_on_adv, clk_i, rst_ni, wr.en, adv && in_q.kind == KindWrite)
  `SAT_ASSERT_IMP(a_stall_needs_item, clk_i, rst_ni, in_stall_o, in_valid_q && out_valid_q)
  `SAT_ASSERT(a_adv_fills_out, clk_i, rst_ni, adv |=> out_valid_q)
  `SAT_ASSERT_IMP(a_fault_range, clk_i, rst_ni, out_valid_q, out_q.fault_code <= FaultNoSeg)
  `SAT_ASSERT(a_reg_no_fault, clk_i, rst_ni, (adv && in_q.kind != KindXlate) |=> (out_q.fault_code == FaultNone && out_q.phys_addr == 32'h0))

endmodule

`default_nettype wire

// ===== rtl/core/sat_regfile.sv =====
// Register bank of the translator: segment words and spare registers in flip-flops.
// Depends on sat_pkg.
`default_nettype none

module sat_regfile (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sat_pkg::sat_wr_t  wr_i,
  output sat_pkg::sat_bank_t     bank_o
);
  import sat_pkg::*;

  sat_bank_t bank_q;

  // All words clear at reset, so every segment starts disabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= '0;
    end else if (wr_i.en) begin
      bank_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign bank_o = bank_q;

endmodule

`default_nettype wire

// ===== rtl/core/sat_xlate.sv =====
// Result logic for one item: segment match, protection checks, register read and write.
// Depends on sat_pkg; purely combinational.
`default_nettype none

module sat_xlate (
  input  wire sat_pkg::sat_in_t   item_i,
  input  wire sat_pkg::sat_bank_t bank_i,
  output sat_pkg::sat_out_t       res_o,
  output sat_pkg::sat_wr_t        wr_o
);
  import sat_pkg::*;

  logic                 pm;
  logic [15:0]          acc;
  logic                 idx_ok;
  logic [NumSegments-1:0] hit;
  logic [2:0]           seg_fc [NumSegments];
  logic [31:0]          seg_pa [NumSegments];
  logic [31:0]          xl_pa;
  logic [2:0]           xl_fc;

  assign pm     = item_i.cpu_status[PmBit];
  assign acc    = item_i.cpu_status[31:16];
  assign idx_ok = {1'b0, item_i.reg_index} < 6'(NumRegs);

  // Per-segment bounds test and fault checks, all segments in parallel.
  for (genvar s = 0; s < NumSegments; s++) begin : g_seg
    logic [31:0] ab;
    logic [31:0] lf;
    logic [15:0] diff;
    assign ab   = bank_i[2*s];
    assign lf   = bank_i[2*s+1];
    assign diff = acc ^ lf[15:0];
    assign hit[s] = lf[SegEnBit]
                 && (item_i.virt_addr >= {ab[31:16], 16'h0000})
                 && (item_i.virt_addr <= {lf[31:16], 16'h0000});

    always_comb begin
      if (!pm) begin
        seg_fc[s] = FaultNone;
      end else if (lf[SegProtBit]) begin
        seg_fc[s] = FaultProt;
      end else if (|(diff & FeMask)) begin
        seg_fc[s] = FaultExec;
      end else if ((|(lf[15:0] & RrwMask)) && (|(diff & FrwMask))) begin
        seg_fc[s] = FaultRw;
      end else begin
        seg_fc[s] = FaultNone;
      end
    end

    assign seg_pa[s] = (seg_fc[s] == FaultNone) ? {ab[15:0], item_i.virt_addr[15:0]}
                                                : item_i.virt_addr;
  end

  // The lowest numbered matching segment decides the result.
  always_comb begin
    xl_pa = item_i.virt_addr;
    xl_fc = pm ? FaultNoSeg : FaultNone;
    for (int s = NumSegments - 1; s >= 0; s--) begin
      if (hit[s]) begin
        xl_pa = seg_pa[s];
        xl_fc = seg_fc[s];
      end
    end
  end

  // Result and write request by item kind.
  always_comb begin
    res_o   = '0;
    wr_o.en   = 1'b0;
    wr_o.idx  = item_i.reg_index[RegIdxW-1:0];
    wr_o.data = item_i.write_data;
    case (item_i.kind)
      KindXlate: begin
        res_o.phys_addr  = xl_pa;
        res_o.fault_code = xl_fc;
      end
      KindRead: begin
        if (idx_ok) begin
          res_o.read_data = bank_i[item_i.reg_index[RegIdxW-1:0]];
        end
      end
      KindWrite: begin
        wr_o.en = idx_ok;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== test/segment_address_translator_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for segment_address_translator_core: register reads and writes
// and address translation with protection checks. Depends on sat_pkg and the core RTL.

module segment_address_translator_core_tb;
  import sat_pkg::*;

  // Kind code that the block treats as a no-op.
  localparam logic [1:0] KindNop = 2'd3;
  localparam int NumRandom = 1800;

  // Translation scoreboard: keeps its own copy of the register bank and
  // predicts each result in acceptance order.
  class xlate_scoreboard;
    logic [31:0] bank [NumRegs];
    sat_out_t    pending_results[$];
    int          n_bad;
    int          n_checked;
    int          fault_seen [5];
    int          n_reads;
    int          n_writes;
    int          n_nop;

    function new();
      foreach (bank[i]) bank[i] = '0;
      foreach (fault_seen[i]) fault_seen[i] = 0;
      n_bad = 0;
      n_checked = 0;
      n_reads = 0;
      n_writes = 0;
      n_nop = 0;
    endfunction

    // Works out the result of one accepted item and updates the bank copy.
    function void note_item(sat_in_t item);
      sat_out_t    res;
      logic        prot_mode;
      logic [15:0] access;
      logic [31:0] addr_word;
      logic [31:0] limit_word;
      logic        found;
      res = '0;
      found = 1'b0;
      case (item.kind)
        KindXlate: begin
          prot_mode = item.cpu_status[PmBit];
          access = item.cpu_status[31:16];
          res.phys_addr = item.virt_addr;
          res.fault_code = prot_mode ? FaultNoSeg : FaultNone;
          // The first enabled segment that holds the address decides the outcome.
          for (int s = 0; s < NumSegments; s++) begin
            addr_word = bank[2 * s];
            limit_word = bank[2 * s + 1];
            if (!found && limit_word[SegEnBit] &&
                item.virt_addr >= {addr_word[31:16], 16'h0000} &&
                item.virt_addr <= {limit_word[31:16], 16'h0000}) begin
              found = 1'b1;
              if (prot_mode && limit_word[SegProtBit]) begin
                res.fault_code = FaultProt;
              end else if (prot_mode && ((access ^ limit_word[15:0]) & FeMask) != '0) begin
                res.fault_code = FaultExec;
              end else if (prot_mode && (limit_word[15:0] & RrwMask) != '0 &&
                           ((access ^ limit_word[15:0]) & FrwMask) != '0) begin
                res.fault_code = FaultRw;
              end else begin
                res.phys_addr = {addr_word[15:0], item.virt_addr[15:0]};
                res.fault_code = FaultNone;
              end
            end
          end
          fault_seen[res.fault_code]++;
        end
        KindRead: begin
          if (item.reg_index < NumRegs) res.read_data = bank[item.reg_index];
          n_reads++;
        end
        KindWrite: begin
          if (item.reg_index < NumRegs) bank[item.reg_index] = item.write_data;
          n_writes++;
        end
        default: begin
          n_nop++;
        end
      endcase
      pending_results.push_back(res);
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_result(sat_out_t got);
      sat_out_t want;
      if (pending_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("Result with no item pending: pa=%h fc=%0d rd=%h",
                   got.phys_addr, got.fault_code, got.read_data);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.phys_addr !== want.phys_addr || got.fault_code !== want.fault_code ||
            got.read_data !== want.read_data) begin
          n_bad++;
          if (n_bad <= 10)
            $display("Mismatch at %0t: expected pa=%h fc=%0d rd=%h, got pa=%h fc=%0d rd=%h",
                     $time, want.phys_addr, want.fault_code, want.read_data,
                     got.phys_addr, got.fault_code, got.read_data);
        end
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  sat_in_t  in_data = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sat_out_t out_data;

  xlate_scoreboard sb = new();

  segment_address_translator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall: switches among no stall, light and heavy random stall and
  // a fixed duty pattern whenever its random countdown runs out.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_cyc = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(64, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_cyc <= stall_cyc + 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_cyc % 7) < 3);
    endcase
  end

  // Both handshakes are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_item(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic sat_in_t mk_item(logic [1:0] k, logic [4:0] idx, logic [31:0] wd,
                                      logic [31:0] va, logic [31:0] st);
    sat_in_t item;
    item.kind = k;
    item.reg_index = idx;
    item.write_data = wd;
    item.virt_addr = va;
    item.cpu_status = st;
    return item;
  endfunction

  // Presents one item and returns at the edge that accepts it.
  task automatic send_item(sat_in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Holds the sender off until every predicted result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  initial begin
    sat_in_t     item;
    int          sel;
    int          s;
    int          burst;
    int          gap;
    logic        fast;
    logic [31:0] addr_word;
    logic [31:0] limit_word;
    logic [31:0] lo32;
    logic [31:0] hi32;
    logic [16:0] sum17;
    logic [15:0] access;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty bank, bounds, each fault, first match and odd indices.
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'hFFFF_FFFF, 32'h0000_0000));
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'h0000_0000, 32'h0000_0001));
    send_item(mk_item(KindRead, 5'd0, 32'h0, 32'h0, 32'h0));
    send_item(mk_item(KindWrite, 5'd0, 32'h1000_ABCD, 32'h0, 32'h0));
    send_item(mk_item(KindWrite, 5'd1, 32'h2000_8000, 32'h0, 32'h0));
    send_item(mk_item(KindWrite, 5'd2, 32'h1800_1234, 32'h0, 32'h0));
    send_item(mk_item(KindWrite, 5'd3, 32'h3000_8001, 32'h0, 32'h0));
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'h1000_0000, 32'h0000_0000));
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'h2000_0000, 32'h0000_0001));
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'h2000_0001, 32'h0000_0001));
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'h2000_0001, 32'h0000_0000));
    send_item(mk_item(KindWrite, 5'd1, 32'h2000_8006, 32'h0, 32'h0));
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'h1800_0000, 32'h0002_0001));
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'h1800_0000, 32'h0000_0001));
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'h1800_0000, 32'h0012_0001));
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'h1FFF_FFFF, 32'hFFFF_FFFE));
    send_item(mk_item(KindWrite, 5'd19, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_item(mk_item(KindRead, 5'd19, 32'h0, 32'h0, 32'h0));
    send_item(mk_item(KindWrite, 5'd20, 32'hDEAD_BEEF, 32'h0, 32'h0));
    send_item(mk_item(KindRead, 5'd20, 32'h0, 32'h0, 32'h0));
    send_item(mk_item(KindRead, 5'd31, 32'h0, 32'h0, 32'h0));
    send_item(mk_item(KindNop, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(KindWrite, 5'd14, 32'hFFFF_0000, 32'h0, 32'h0));
    send_item(mk_item(KindWrite, 5'd15, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_item(mk_item(KindXlate, 5'd0, 32'h0, 32'hFFFF_0000, 32'h0000_0000));
    drain_results();

    // Random part: mostly translations aimed at live segments, mixed with
    // segment rewrites, reads anywhere in the index range and no-op items.
    burst = 0;
    fast = 1'b0;
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) drain_results();
      if (burst == 0) begin
        fast = ($urandom_range(0, 3) == 0);
        gap = fast ? 0 : $urandom_range(1, 6);
        idle_cycles(gap);
        burst = $urandom_range(1, 30);
      end
      burst--;

      item.kind = KindXlate;
      item.reg_index = 5'($urandom_range(0, 31));
      item.write_data = $urandom;
      item.virt_addr = $urandom;
      item.cpu_status = $urandom;
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        item.kind = KindWrite;
        if ($urandom_range(0, 3) != 0)
          item.reg_index = 5'($urandom_range(0, 2 * NumSegments - 1));
        // Limit words get a bound at or above the base bound of their segment.
        if (item.reg_index < 2 * NumSegments && item.reg_index[0] &&
            $urandom_range(0, 7) != 0) begin
          addr_word = sb.bank[item.reg_index - 1];
          sum17 = {1'b0, addr_word[31:16]} + 17'($urandom_range(0, 16'h0400));
          item.write_data[31:16] = sum17[16] ? 16'hFFFF : sum17[15:0];
          item.write_data[SegEnBit] = ($urandom_range(0, 4) != 0);
          item.write_data[SegProtBit] = ($urandom_range(0, 4) == 0);
        end
      end else if (sel < 20) begin
        item.kind = KindRead;
      end else if (sel < 23) begin
        item.kind = KindNop;
      end else begin
        s = $urandom_range(0, NumSegments - 1);
        addr_word = sb.bank[2 * s];
        limit_word = sb.bank[2 * s + 1];
        lo32 = {addr_word[31:16], 16'h0000};
        hi32 = {limit_word[31:16], 16'h0000};
        if ($urandom_range(0, 4) != 0 && hi32 >= lo32) begin
          case ($urandom_range(0, 5))
            0: item.virt_addr = lo32;
            1: item.virt_addr = hi32;
            2: item.virt_addr = lo32 - 1;
            3: item.virt_addr = hi32 + 1;
            default: item.virt_addr = lo32 + $urandom_range(0, hi32 - lo32);
          endcase
        end
        // Access bits follow the segment flags half of the time, with a single flip now and then.
        if ($urandom_range(0, 1) != 0) begin
          access = limit_word[15:0];
          if ($urandom_range(0, 2) == 0) access = access ^ (16'd1 << $urandom_range(1, 4));
          item.cpu_status[31:16] = access;
        end
        item.cpu_status[PmBit] = ($urandom_range(0, 3) != 0);
      end
      send_item(item);
    end
    drain_results();
    repeat (4) @(posedge clk);

    $display("Checked %0d results over %0d random and 25 directed items.",
             sb.n_checked, NumRandom);
    $display("Translations ok/prot/exec/rw/noseg: %0d/%0d/%0d/%0d/%0d; reads %0d, writes %0d, no-ops %0d.",
             sb.fault_seen[FaultNone], sb.fault_seen[FaultProt], sb.fault_seen[FaultExec],
             sb.fault_seen[FaultRw], sb.fault_seen[FaultNoSeg], sb.n_reads, sb.n_writes,
             sb.n_nop);
    if (sb.n_bad == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("Failures: %0d, results still pending: %0d", sb.n_bad,
               sb.pending_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results pending", sb.pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
